// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication check, clocked on rising edge, off during reset
`define BBR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication check
`define BBR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/bbr_pkg.sv -----
`timescale 1ns / 1ps
package bbr_pkg;

  localparam int DEF_MAX_BUCKETS = 1024;
  localparam int DEF_MAX_HOSTS   = 16;

  localparam int CNT_W  = 11;
  localparam int HCNT_W = 5;
  localparam int MASK_W = 16;
  localparam int ID_W   = 10;
  localparam int HOST_W = 4;
  localparam int ST_W   = 3;
  localparam int ERR_W  = 3;
  localparam int ENT_W  = HOST_W + 1;

  localparam logic [ST_W-1:0] ST_PEND      = 3'd0;
  localparam logic [ST_W-1:0] ST_CHANGED   = 3'd1;
  localparam logic [ST_W-1:0] ST_SAME      = 3'd2;
  localparam logic [ST_W-1:0] ST_MALFORMED = 3'd3;
  localparam logic [ST_W-1:0] ST_FAIL      = 3'd4;

  localparam logic [ERR_W-1:0] ERR_NONE = 3'd0;
  localparam logic [ERR_W-1:0] ERR_MALF = 3'd3;
  localparam logic [ERR_W-1:0] ERR_OVFL = 3'd4;

  localparam logic CFG_BUCKETS = 1'b0;
  localparam logic CFG_MASK    = 1'b1;

  localparam logic [CNT_W-1:0]  RST_BUCKETS = 11'd101;
  localparam logic [MASK_W-1:0] RST_MASK    = 16'd1;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_RD,
    S_FILL_RD,
    S_FILL_WR,
    S_DIV
  } fsm_e;

endpackage

// ----- sv/bbr_div.sv -----
`timescale 1ns / 1ps
module bbr_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bbr_pkg::CNT_W-1:0]  dividend_i,
  input  logic [bbr_pkg::HCNT_W-1:0] divisor_i,
  output logic                       busy_o,
  output logic [bbr_pkg::CNT_W-1:0]  quo_o,
  output logic [bbr_pkg::HCNT_W-1:0] rem_o
);

  localparam int CW = $clog2(bbr_pkg::CNT_W + 1);

  logic                       run_q, run_d;
  logic [CW-1:0]              cnt_q, cnt_d;
  logic [bbr_pkg::CNT_W-1:0]  quo_q, quo_d;
  logic [bbr_pkg::HCNT_W-1:0] rem_q, rem_d;
  logic [bbr_pkg::HCNT_W-1:0] trial;
  logic                       ge;

  always_comb begin
    trial = {rem_q[bbr_pkg::HCNT_W-2:0], quo_q[bbr_pkg::CNT_W-1]};
    ge    = trial >= divisor_i;
    run_d = run_q;
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = CW'(bbr_pkg::CNT_W);
      quo_d = dividend_i;
      rem_d = '0;
    end else if (run_q) begin
      quo_d = {quo_q[bbr_pkg::CNT_W-2:0], ge};
      rem_d = ge ? trial - divisor_i : trial;
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign busy_o = run_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// ----- sv/bbr_ram.sv -----
`timescale 1ns / 1ps
module bbr_ram #(
  parameter int DEPTH = bbr_pkg::DEF_MAX_BUCKETS,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [bbr_pkg::ENT_W-1:0] wdata_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [bbr_pkg::ENT_W-1:0] rdata_o
);

  logic [bbr_pkg::ENT_W-1:0] mem [DEPTH];
  logic [bbr_pkg::ENT_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/balanced_bucket_reassigner.sv -----
`timescale 1ns / 1ps
// channel   direction  handshake              payload
// request   in         start & !busy          mode, has_owner, owner_host, bucket_id,
//                                             malformed, last_entry
// result    out        done_o, one cycle      status, new_owner, read_bucket
// config    in         cfg_we_i               cfg_idx_i, cfg_data_i
//
// A load result follows in the next cycle; a read passes through S_RD for the owner
// memory read. A last entry walks all MAX_BUCKETS entries, each read in S_FILL_RD and,
// below the bucket count, written back in S_FILL_WR through the owner memory port; an
// error ends it in a clear sweep of all entries. Reset starts a clear sweep too; each
// config write holds busy through an 11 step quota division. busy is high in all of
// these but a non-last load. The receiver cannot stall: done_o lasts one cycle.
module balanced_bucket_reassigner #(
  parameter int MAX_BUCKETS = bbr_pkg::DEF_MAX_BUCKETS,
  parameter int MAX_HOSTS   = bbr_pkg::DEF_MAX_HOSTS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       mode_i,
  input  logic                       has_owner_i,
  input  logic [bbr_pkg::HOST_W-1:0] owner_host_i,
  input  logic [bbr_pkg::ID_W-1:0]   bucket_id_i,
  input  logic                       malformed_i,
  input  logic                       last_entry_i,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [bbr_pkg::MASK_W-1:0] cfg_data_i,
  output logic                       done_o,
  output logic [bbr_pkg::ST_W-1:0]   status_o,
  output logic [bbr_pkg::HOST_W-1:0] new_owner_o,
  output logic [bbr_pkg::ID_W-1:0]   read_bucket_o
);

`include "assert_macros.svh"

  localparam int NH = (MAX_HOSTS < 16) ? MAX_HOSTS : 16;
  localparam int HW = (NH > 1) ? $clog2(NH) : 1;
  localparam int AW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int CW = ((AW > bbr_pkg::CNT_W) ? AW : bbr_pkg::CNT_W) + 1;
  localparam int QW = bbr_pkg::CNT_W + 1;

  bbr_pkg::fsm_e state_q, state_d;

  logic [bbr_pkg::CNT_W-1:0]  bc_q, bc_d;
  logic [bbr_pkg::MASK_W-1:0] mask_q, mask_d;
  logic                       stale_q, stale_d;
  logic [bbr_pkg::CNT_W-1:0]  hl_q [NH];
  logic [bbr_pkg::CNT_W-1:0]  hl_d [NH];
  logic [bbr_pkg::CNT_W-1:0]  ent_q, ent_d;
  logic [bbr_pkg::HCNT_W-1:0] ceil_q, ceil_d;
  logic                       chg_q, chg_d;
  logic [bbr_pkg::ERR_W-1:0]  err_q, err_d;
  logic [AW-1:0]              b_q, b_d;
  logic                       rep_q, rep_d;
  logic [bbr_pkg::ST_W-1:0]   rep_st_q, rep_st_d;
  logic [bbr_pkg::ID_W-1:0]   rd_id_q, rd_id_d;
  logic                       rd_in_q, rd_in_d;
  logic                       done_q, done_d;
  logic [bbr_pkg::ST_W-1:0]   st_q, st_d;
  logic [bbr_pkg::HOST_W-1:0] own_q, own_d;
  logic [bbr_pkg::ID_W-1:0]   rbk_q, rbk_d;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [bbr_pkg::ENT_W-1:0]  ram_wdata, ram_rdata;

  logic                       div_start, div_busy;
  logic [bbr_pkg::CNT_W-1:0]  low;
  logic [bbr_pkg::HCNT_W-1:0] hn;
  logic [QW-1:0]              high;

  logic [bbr_pkg::CNT_W-1:0]  nb;
  logic [bbr_pkg::HCNT_W-1:0] n_live;
  logic                       acc, at_end, b_ge_nb, skip;
  logic [NH-1:0]              elig;
  logic                       hit;
  logic [HW-1:0]              sel;
  logic                       idx_ok, host_ok, host_live, cand, keep, keep_ceil;
  logic [bbr_pkg::CNT_W-1:0]  cn;
  logic [bbr_pkg::ERR_W-1:0]  err_ld;
  logic                       ld_fail;

  always_comb begin
    nb = (CW'(bc_q) < CW'(MAX_BUCKETS)) ? bc_q : bbr_pkg::CNT_W'(MAX_BUCKETS);
    n_live = '0;
    for (int h = 0; h < NH; h++) begin
      n_live = n_live + bbr_pkg::HCNT_W'(mask_q[h]);
    end
  end

  assign high = {1'b0, low} + QW'(1);
  assign busy = (state_q != bbr_pkg::S_IDLE) || stale_q;
  assign acc  = start && !busy;

  always_comb begin
    at_end  = b_q == AW'(MAX_BUCKETS - 1);
    b_ge_nb = CW'(b_q) >= CW'(nb);
    skip    = (CW'(b_q) < CW'(ent_q)) && ram_rdata[bbr_pkg::ENT_W-1];
    for (int h = 0; h < NH; h++) begin
      elig[h] = mask_q[h] && ({1'b0, hl_q[h]} < high) &&
                !((hl_q[h] == low) && (ceil_q >= hn));
    end
    hit = |elig;
    sel = '0;
    for (int h = NH - 1; h >= 0; h--) begin
      if (elig[h]) begin
        sel = HW'(h);
      end
    end
  end

  always_comb begin
    idx_ok    = CW'(ent_q) < CW'(nb);
    host_ok   = {1'b0, owner_host_i} < (bbr_pkg::HOST_W + 1)'(NH);
    host_live = host_ok && mask_q[owner_host_i];
    cn        = host_ok ? hl_q[owner_host_i[HW-1:0]] : '0;
    cand      = has_owner_i && host_live && ({1'b0, bucket_id_i} == ent_q) &&
                (n_live != '0);
    keep      = 1'b0;
    keep_ceil = 1'b0;
    if (cand) begin
      if ({1'b0, cn} >= high) begin
        keep = 1'b0;
      end else if (cn == low) begin
        keep      = ceil_q < hn;
        keep_ceil = keep;
      end else begin
        keep = 1'b1;
      end
    end
    if (malformed_i) begin
      err_ld = bbr_pkg::ERR_MALF;
    end else if (!idx_ok && (err_q == bbr_pkg::ERR_NONE)) begin
      err_ld = bbr_pkg::ERR_OVFL;
    end else begin
      err_ld = err_q;
    end
    ld_fail = (err_ld != bbr_pkg::ERR_NONE) || (n_live == '0);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bbr_pkg::S_CLR: begin
        if (at_end) state_d = bbr_pkg::S_IDLE;
      end
      bbr_pkg::S_IDLE: begin
        if (stale_q) begin
          state_d = bbr_pkg::S_DIV;
        end else if (acc) begin
          if (mode_i) state_d = bbr_pkg::S_RD;
          else if (last_entry_i) state_d = ld_fail ? bbr_pkg::S_CLR : bbr_pkg::S_FILL_RD;
        end
      end
      bbr_pkg::S_RD: state_d = bbr_pkg::S_IDLE;
      bbr_pkg::S_FILL_RD: begin
        if (!b_ge_nb) state_d = bbr_pkg::S_FILL_WR;
        else if (at_end) state_d = bbr_pkg::S_IDLE;
      end
      bbr_pkg::S_FILL_WR: begin
        if (!skip && !hit) state_d = bbr_pkg::S_CLR;
        else if (at_end) state_d = bbr_pkg::S_IDLE;
        else state_d = bbr_pkg::S_FILL_RD;
      end
      bbr_pkg::S_DIV: begin
        if (!div_busy) state_d = bbr_pkg::S_IDLE;
      end
      default: state_d = bbr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    bc_d      = bc_q;
    mask_d    = mask_q;
    stale_d   = stale_q;
    hl_d      = hl_q;
    ent_d     = ent_q;
    ceil_d    = ceil_q;
    chg_d     = chg_q;
    err_d     = err_q;
    b_d       = b_q;
    rep_d     = rep_q;
    rep_st_d  = rep_st_q;
    rd_id_d   = rd_id_q;
    rd_in_d   = rd_in_q;
    done_d    = 1'b0;
    st_d      = st_q;
    own_d     = own_q;
    rbk_d     = rbk_q;
    ram_we    = 1'b0;
    ram_waddr = b_q;
    ram_wdata = '0;
    ram_raddr = (state_q == bbr_pkg::S_IDLE) ? AW'(bucket_id_i) : b_q;
    div_start = 1'b0;

    if (cfg_we_i) begin
      stale_d = 1'b1;
      if (cfg_idx_i == bbr_pkg::CFG_BUCKETS) bc_d = cfg_data_i[bbr_pkg::CNT_W-1:0];
      else mask_d = cfg_data_i;
    end

    unique case (state_q)
      bbr_pkg::S_CLR: begin
        ram_we = 1'b1;
        if (at_end) begin
          b_d = '0;
          if (rep_q) begin
            done_d = 1'b1;
            st_d   = rep_st_q;
            own_d  = '0;
            rbk_d  = '0;
            rep_d  = 1'b0;
          end
        end else begin
          b_d = b_q + AW'(1);
        end
      end
      bbr_pkg::S_IDLE: begin
        if (stale_q) begin
          div_start = 1'b1;
          stale_d   = cfg_we_i;
        end else if (acc && mode_i) begin
          rd_id_d = bucket_id_i;
          rd_in_d = ({1'b0, bucket_id_i} < nb) &&
                    ((bbr_pkg::ID_W + 7)'(bucket_id_i) < (bbr_pkg::ID_W + 7)'(MAX_BUCKETS));
        end else if (acc) begin
          if (!malformed_i && idx_ok) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(ent_q);
            ram_wdata = keep ? {1'b1, owner_host_i} : '0;
            if (keep) hl_d[owner_host_i[HW-1:0]] = cn + bbr_pkg::CNT_W'(1);
            if (keep_ceil) ceil_d = ceil_q + bbr_pkg::HCNT_W'(1);
            if (!keep) chg_d = 1'b1;
          end
          if (ent_q != '1) ent_d = ent_q + bbr_pkg::CNT_W'(1);
          err_d = err_ld;
          if (!last_entry_i) begin
            done_d = 1'b1;
            st_d   = bbr_pkg::ST_PEND;
            own_d  = '0;
            rbk_d  = '0;
          end else begin
            b_d = '0;
            if (ld_fail) begin
              rep_d    = 1'b1;
              rep_st_d = (err_ld == bbr_pkg::ERR_MALF) ? bbr_pkg::ST_MALFORMED
                                                      : bbr_pkg::ST_FAIL;
              for (int h = 0; h < NH; h++) hl_d[h] = '0;
              ent_d  = '0;
              ceil_d = '0;
              chg_d  = 1'b0;
              err_d  = bbr_pkg::ERR_NONE;
            end
          end
        end
      end
      bbr_pkg::S_RD: begin
        done_d = 1'b1;
        st_d   = bbr_pkg::ST_PEND;
        own_d  = (rd_in_q && ram_rdata[bbr_pkg::ENT_W-1]) ?
                 ram_rdata[bbr_pkg::HOST_W-1:0] : '0;
        rbk_d  = rd_id_q;
      end
      bbr_pkg::S_FILL_RD, bbr_pkg::S_FILL_WR: begin
        if (state_q == bbr_pkg::S_FILL_RD && b_ge_nb) begin
          ram_we = 1'b1;
        end else if (state_q == bbr_pkg::S_FILL_WR && !skip) begin
          chg_d = 1'b1;
          if (hit) begin
            ram_we    = 1'b1;
            ram_wdata = {1'b1, bbr_pkg::HOST_W'(sel)};
            hl_d[sel] = hl_q[sel] + bbr_pkg::CNT_W'(1);
            if ({1'b0, hl_q[sel]} + QW'(1) == high) ceil_d = ceil_q + bbr_pkg::HCNT_W'(1);
          end
        end
        if (state_q == bbr_pkg::S_FILL_WR && !skip && !hit) begin
          b_d      = '0;
          rep_d    = 1'b1;
          rep_st_d = bbr_pkg::ST_FAIL;
          for (int h = 0; h < NH; h++) hl_d[h] = '0;
          ent_d  = '0;
          ceil_d = '0;
          chg_d  = 1'b0;
          err_d  = bbr_pkg::ERR_NONE;
        end else if (state_q == bbr_pkg::S_FILL_WR || b_ge_nb) begin
          if (at_end) begin
            done_d = 1'b1;
            st_d   = chg_d ? bbr_pkg::ST_CHANGED : bbr_pkg::ST_SAME;
            own_d  = '0;
            rbk_d  = '0;
            b_d    = '0;
            for (int h = 0; h < NH; h++) hl_d[h] = '0;
            ent_d  = '0;
            ceil_d = '0;
            chg_d  = 1'b0;
            err_d  = bbr_pkg::ERR_NONE;
          end else begin
            b_d = b_q + AW'(1);
          end
        end
      end
      bbr_pkg::S_DIV: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= bbr_pkg::S_CLR;
      bc_q     <= bbr_pkg::RST_BUCKETS;
      mask_q   <= bbr_pkg::RST_MASK;
      stale_q  <= 1'b1;
      for (int h = 0; h < NH; h++) hl_q[h] <= '0;
      ent_q    <= '0;
      ceil_q   <= '0;
      chg_q    <= 1'b0;
      err_q    <= bbr_pkg::ERR_NONE;
      b_q      <= '0;
      rep_q    <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      bc_q     <= bc_d;
      mask_q   <= mask_d;
      stale_q  <= stale_d;
      hl_q     <= hl_d;
      ent_q    <= ent_d;
      ceil_q   <= ceil_d;
      chg_q    <= chg_d;
      err_q    <= err_d;
      b_q      <= b_d;
      rep_q    <= rep_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rep_st_q <= rep_st_d;
    rd_id_q  <= rd_id_d;
    rd_in_q  <= rd_in_d;
    st_q     <= st_d;
    own_q    <= own_d;
    rbk_q    <= rbk_d;
  end

  bbr_ram #(
    .DEPTH (MAX_BUCKETS),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bbr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (nb),
    .divisor_i  (n_live),
    .busy_o     (div_busy),
    .quo_o      (low),
    .rem_o      (hn)
  );

  assign done_o        = done_q;
  assign status_o      = st_q;
  assign new_owner_o   = own_q;
  assign read_bucket_o = rbk_q;

  `BBR_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_o, state_q == bbr_pkg::S_IDLE, "result outside idle")
  `BBR_ASSERT_NXT(a_read_lat, clk_i, rst_ni, acc && mode_i, ##1 done_o, "read result missing")
  `BBR_ASSERT_NXT(a_load_lat, clk_i, rst_ni, acc && !mode_i && !last_entry_i, done_o, "load result missing")

endmodule
